/* src/btpc_pkg.sv */
// Shared types, constants and arithmetic helpers for the barometric compensation pipeline.
`timescale 1ns / 1ps
`default_nettype none
package btpc_pkg;

    typedef logic signed [31:0] s32_t;

    // Register indexes on the configuration channel
    localparam logic [7:0] REG_TEMP_COEFFS   = 8'd0;
    localparam logic [7:0] REG_PRESS_A       = 8'd1;
    localparam logic [7:0] REG_PRESS_B       = 8'd2;
    localparam logic [7:0] REG_PRESS_NINE    = 8'd3;

    // Pipeline layout: front polynomial stages, divider stages, back stages
    localparam int FRONT_STAGES = 13;
    localparam int DIV_STAGES   = 32;
    localparam int DIV_FIRST    = FRONT_STAGES;
    localparam int BACK_FIRST   = FRONT_STAGES + DIV_STAGES;
    localparam int NUM_STAGES   = BACK_FIRST + 4;

    // Stages where side-band fields are first known
    localparam int ST_TEMP  = 4;
    localparam int ST_FAULT = 11;
    localparam int ST_BIG   = 12;

    localparam s32_t TEMP_MAX = 32'sd8388607;
    localparam s32_t TEMP_MIN = -32'sd8388608;

    typedef struct packed {
        logic [19:0]        adc_p;
        logic signed [23:0] temp;
        logic               fault;
        logic               big;
    } side_t;

    // Sign-extend a 16-bit coefficient
    function automatic s32_t sext16(input logic [15:0] v);
        return s32_t'({{16{v[15]}}, v});
    endfunction

    // Signed division by 2**k, truncating toward zero
    function automatic s32_t sdiv_p2(input s32_t x, input int unsigned k);
        logic [31:0] bias;
        bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        return (x + s32_t'(bias)) >>> k;
    endfunction

endpackage
`default_nettype wire

/* src/baro_temp_press_compensate.sv */
// Top level: pipelined integer temperature and pressure compensation.
`timescale 1ns / 1ps
`default_nettype none
// One sample pair enters and one result leaves per clock while m_tready is high. The
// pipeline has 13 stages of calibration polynomial (at most one multiply level each), 32
// stages of the unsigned pressure divider (one quotient bit per stage), and 4 stages of
// final correction, the last being the output register. Each stage has its own valid bit
// and moves up whenever the stage after it is empty or moving, so bubbles collapse under a
// stall and the input side keeps accepting until the pipeline is truly full. Coefficients
// are read live by the stages and must only be written while the pipeline is empty.
module baro_temp_press_compensate
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // temperature_centi[23:0], pressure_pa[55:24],
                                        // divide_fault[56], zero fill above
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import btpc_pkg::*;

    // Coefficient registers
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_a_reg;
    logic [63:0] press_b_reg;
    logic [15:0] press_nine_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_a_reg     <= '0;
            press_b_reg     <= '0;
            press_nine_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                REG_PRESS_A:     press_a_reg     <= cfg_data;
                REG_PRESS_B:     press_b_reg     <= cfg_data;
                REG_PRESS_NINE:  press_nine_reg  <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    s32_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = s32_t'({16'd0, temp_coeffs_reg[15:0]});
    assign t2 = sext16(temp_coeffs_reg[31:16]);
    assign t3 = sext16(temp_coeffs_reg[47:32]);
    assign p1 = s32_t'({16'd0, press_a_reg[15:0]});
    assign p2 = sext16(press_a_reg[31:16]);
    assign p3 = sext16(press_a_reg[47:32]);
    assign p4 = sext16(press_a_reg[63:48]);
    assign p5 = sext16(press_b_reg[15:0]);
    assign p6 = sext16(press_b_reg[31:16]);
    assign p7 = sext16(press_b_reg[47:32]);
    assign p8 = sext16(press_b_reg[63:48]);
    assign p9 = sext16(press_nine_reg);

    // Valid bits and per-stage advance chain
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES:0]   rdy;
    side_t side_reg  [NUM_STAGES];
    side_t side_next [NUM_STAGES];

    always_comb
    begin
        rdy[NUM_STAGES] = m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign s_tready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[0])
                v_reg[0] <= s_tvalid;
            for (int k = 1; k < NUM_STAGES; k++)
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // Front stage registers
    s32_t x1_reg, d_reg;                    // stage 0
    s32_t m1_reg, dd_reg;                   // stage 1
    s32_t a11_reg, m2_reg;                  // stage 2
    s32_t fine_reg;                         // stage 3
    s32_t pa_reg;                           // stage 4
    s32_t q_reg, pa5_reg, p2a_reg;          // stage 5
    s32_t qq_reg, pa5x2_reg, p2a2_reg;      // stage 6
    s32_t b6_reg, q8_reg, pa5x2_7_reg, p2a2_7_reg;  // stage 7
    s32_t bsum_reg, m3_reg, p2a2_8_reg;     // stage 8
    s32_t bf_reg, af_reg;                   // stage 9
    s32_t am_reg, bf10_reg;                 // stage 10
    s32_t dv_reg, nb_reg;                   // stage 11
    logic [31:0] pn_reg, dvs12_reg;         // stage 12

    // Temperature rounding and saturation
    s32_t tm, t8;
    logic signed [23:0] temp_sat;
    assign tm = fine_reg * 32'sd5 + 32'sd128;
    assign t8 = tm >>> 8;
    always_comb
    begin
        if (t8 > TEMP_MAX)
            temp_sat = TEMP_MAX[23:0];
        else if (t8 < TEMP_MIN)
            temp_sat = TEMP_MIN[23:0];
        else
            temp_sat = t8[23:0];
    end

    s32_t dv_next;
    assign dv_next = sdiv_p2(am_reg, 15);

    logic [31:0] pn_next;
    logic        pn_next_big;
    assign pn_next     = 32'(nb_reg * 32'sd3125);
    assign pn_next_big = pn_next[31];

    // Side-band fields ride along and are filled in where they become known
    always_comb
    begin
        side_next[0] = side_reg[0];
        side_next[0].adc_p = s_tdata[39:20];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            side_next[k] = side_reg[k-1];
            if (k == ST_TEMP)
                side_next[k].temp = temp_sat;
            if (k == ST_FAULT)
                side_next[k].fault = (dv_next == 32'sd0);
            if (k == ST_BIG)
                side_next[k].big = pn_next_big;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STAGES; k++)
            if (rdy[k])
                side_reg[k] <= side_next[k];
    end

    // Front polynomial pipeline
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x1_reg <= s32_t'({15'd0, s_tdata[19:3]}) - (t1 <<< 1);
            d_reg  <= s32_t'({16'd0, s_tdata[19:4]}) - t1;
        end
        if (rdy[1])
        begin
            m1_reg <= x1_reg * t2;
            dd_reg <= d_reg * d_reg;
        end
        if (rdy[2])
        begin
            a11_reg <= m1_reg >>> 11;
            m2_reg  <= (dd_reg >>> 12) * t3;
        end
        if (rdy[3])
            fine_reg <= a11_reg + (m2_reg >>> 14);
        if (rdy[4])
            pa_reg <= sdiv_p2(fine_reg, 1) - 32'sd64000;
        if (rdy[5])
        begin
            q_reg   <= sdiv_p2(pa_reg, 2);
            pa5_reg <= pa_reg * p5;
            p2a_reg <= p2 * pa_reg;
        end
        if (rdy[6])
        begin
            qq_reg    <= q_reg * q_reg;
            pa5x2_reg <= pa5_reg <<< 1;
            p2a2_reg  <= sdiv_p2(p2a_reg, 1);
        end
        if (rdy[7])
        begin
            b6_reg      <= sdiv_p2(qq_reg, 11) * p6;
            q8_reg      <= sdiv_p2(qq_reg, 13);
            pa5x2_7_reg <= pa5x2_reg;
            p2a2_7_reg  <= p2a2_reg;
        end
        if (rdy[8])
        begin
            bsum_reg   <= b6_reg + pa5x2_7_reg;
            m3_reg     <= p3 * q8_reg;
            p2a2_8_reg <= p2a2_7_reg;
        end
        if (rdy[9])
        begin
            bf_reg <= sdiv_p2(bsum_reg, 2) + (p4 <<< 16);
            af_reg <= sdiv_p2(sdiv_p2(m3_reg, 3) + p2a2_8_reg, 18);
        end
        if (rdy[10])
        begin
            am_reg   <= (32'sd32768 + af_reg) * p1;
            bf10_reg <= bf_reg;
        end
        if (rdy[11])
        begin
            dv_reg <= dv_next;
            nb_reg <= (32'sd1048576 - s32_t'({12'd0, side_reg[10].adc_p}))
                      - sdiv_p2(bf10_reg, 12);
        end
        if (rdy[12])
        begin
            pn_reg    <= pn_next;
            dvs12_reg <= dv_reg;
        end
    end

    // Restoring unsigned divider, one quotient bit per stage
    logic [31:0] rem_reg [DIV_STAGES];
    logic [31:0] nq_reg  [DIV_STAGES];
    logic [31:0] dvs_reg [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        logic [31:0] rin, nin, din;
        logic [32:0] trial;
        logic        qbit;
        if (j == 0)
        begin : g_first
            assign rin = '0;
            assign nin = side_reg[ST_BIG].big ? pn_reg : (pn_reg << 1);
            assign din = dvs12_reg;
        end
        else
        begin : g_rest
            assign rin = rem_reg[j-1];
            assign nin = nq_reg[j-1];
            assign din = dvs_reg[j-1];
        end
        assign trial = {rin, nin[31]};
        assign qbit  = (trial >= {1'b0, din});

        always_ff @(posedge clk)
        begin
            if (rdy[DIV_FIRST + j])
            begin
                rem_reg[j] <= qbit ? 32'(trial - {1'b0, din}) : trial[31:0];
                nq_reg[j]  <= {nin[30:0], qbit};
                dvs_reg[j] <= din;
            end
        end
    end

    // Back stages: second-order correction
    logic [31:0] pres_div;
    logic [31:0] e_val;
    assign pres_div = side_reg[BACK_FIRST-1].big ? (nq_reg[DIV_STAGES-1] << 1)
                                                 : nq_reg[DIV_STAGES-1];
    assign e_val    = pres_div >> 3;

    logic [31:0] pres_a_reg, ee_reg, pres_b_reg, pres_c_reg;
    s32_t mb_reg, m9_reg, bb_reg, sum_reg;
    logic [31:0] pres_out_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[BACK_FIRST])
        begin
            pres_a_reg <= pres_div;
            ee_reg     <= e_val * e_val;
            mb_reg     <= s32_t'(pres_div >> 2) * p8;
        end
        if (rdy[BACK_FIRST+1])
        begin
            m9_reg     <= p9 * s32_t'(ee_reg >> 13);
            bb_reg     <= sdiv_p2(mb_reg, 13);
            pres_b_reg <= pres_a_reg;
        end
        if (rdy[BACK_FIRST+2])
        begin
            sum_reg    <= sdiv_p2(m9_reg, 12) + bb_reg + p7;
            pres_c_reg <= pres_b_reg;
        end
        if (rdy[BACK_FIRST+3])
            pres_out_reg <= side_reg[BACK_FIRST+2].fault ? 32'd0
                          : 32'(s32_t'(pres_c_reg) + sdiv_p2(sum_reg, 4));
    end

    assign m_tvalid = v_reg[NUM_STAGES-1];
    assign m_tdata  = {7'd0, side_reg[NUM_STAGES-1].fault, pres_out_reg,
                       side_reg[NUM_STAGES-1].temp};

    // Checks
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[56] |-> m_tdata[55:24] == 32'd0)
        else $error("fault result carries nonzero pressure");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> v_reg[0] && !rdy[1])
        else $error("input stalled while first stage can move");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[BACK_FIRST-1] && dvs_reg[DIV_STAGES-1] != 32'd0
        |-> rem_reg[DIV_STAGES-1] < dvs_reg[DIV_STAGES-1])
        else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for the barometric temperature and pressure compensation pipeline.
`timescale 1ns / 1ps

// Tracks expected compensation results in request order and checks each output.
class comp_scoreboard;
    typedef struct {
        logic [23:0] temp_centi;
        logic [31:0] press_pa;
        logic        div_fault;
    } comp_result_t;

    comp_result_t pending[$];
    int           errors;

    function void note_request(logic [23:0] t, logic [31:0] p, logic f);
        comp_result_t r;
        r.temp_centi = t;
        r.press_pa   = p;
        r.div_fault  = f;
        pending.push_back(r);
    endfunction

    // Returns a mismatch text, empty when the result matches
    function string check_result(logic [63:0] data);
        comp_result_t r;
        string        msg;
        msg = "";
        if (pending.size() == 0)
            return $sformatf("unexpected result %h", data);
        r = pending.pop_front();
        if (data[23:0] !== r.temp_centi)
            msg = {msg, $sformatf(" temp got %h exp %h", data[23:0], r.temp_centi)};
        if (data[55:24] !== r.press_pa)
            msg = {msg, $sformatf(" press got %h exp %h", data[55:24], r.press_pa)};
        if (data[56] !== r.div_fault)
            msg = {msg, $sformatf(" fault got %b exp %b", data[56], r.div_fault)};
        if (data[63:57] !== 7'd0)
            msg = {msg, " nonzero fill"};
        return msg;
    endfunction
endclass

module tb_top;
    import btpc_pkg::*;

    localparam int LATENCY = NUM_STAGES;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [63:0] cfg_data;

    // Local copy of the coefficient registers
    logic [47:0] k_temp;
    logic [63:0] k_press_a;
    logic [63:0] k_press_b;
    logic [15:0] k_press_nine;

    comp_scoreboard sb;
    int  mismatches;
    bit  rx_idle_en;
    int  rx_hold;
    bit  long_hold_go;
    bit  long_hold_done;

    baro_temp_press_compensate u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // 32-bit wrapping helpers, signed division truncates toward zero
    function automatic s32_t wmul(s32_t a, s32_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return s32_t'(p[31:0]);
    endfunction

    function automatic s32_t tdiv(s32_t a, s32_t d);
        logic signed [63:0] q;
        q = 64'(a) / 64'(d);
        return s32_t'(q[31:0]);
    endfunction

    function automatic s32_t c16(logic [15:0] v);
        return s32_t'(signed'(v));
    endfunction

    // Compensation of one raw pair under the current coefficients
    task automatic compensate(input logic [19:0] raw_t, input logic [19:0] raw_p,
                              output logic [23:0] t_out, output logic [31:0] p_out,
                              output logic fault);
        s32_t adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        s32_t a, b, d, fine, tc, q;
        logic [31:0] pr, dv, e;
        adc_t = s32_t'({12'd0, raw_t});
        adc_p = s32_t'({12'd0, raw_p});
        t1 = s32_t'({16'd0, k_temp[15:0]});
        t2 = c16(k_temp[31:16]);
        t3 = c16(k_temp[47:32]);
        p1 = s32_t'({16'd0, k_press_a[15:0]});
        p2 = c16(k_press_a[31:16]);
        p3 = c16(k_press_a[47:32]);
        p4 = c16(k_press_a[63:48]);
        p5 = c16(k_press_b[15:0]);
        p6 = c16(k_press_b[31:16]);
        p7 = c16(k_press_b[47:32]);
        p8 = c16(k_press_b[63:48]);
        p9 = c16(k_press_nine);

        // temperature path
        a = wmul((adc_t >>> 3) - (t1 <<< 1), t2) >>> 11;
        d = (adc_t >>> 4) - t1;
        b = wmul(wmul(d, d) >>> 12, t3) >>> 14;
        fine = a + b;
        tc = (wmul(fine, 5) + 128) >>> 8;
        if (tc > 8388607)
            tc = 8388607;
        if (tc < -8388608)
            tc = -8388608;
        t_out = tc[23:0];

        // pressure path
        a = tdiv(fine, 2) - 64000;
        q = tdiv(a, 4);
        b = wmul(tdiv(wmul(q, q), 2048), p6);
        b = b + wmul(wmul(a, p5), 2);
        b = tdiv(b, 4) + wmul(p4, 65536);
        a = tdiv(tdiv(wmul(p3, tdiv(wmul(q, q), 8192)), 8) + tdiv(wmul(p2, a), 2), 262144);
        a = tdiv(wmul(32768 + a, p1), 32768);
        if (a == 0)
        begin
            p_out = 32'd0;
            fault = 1'b1;
        end
        else
        begin
            dv = a;
            pr = wmul((1048576 - adc_p) - tdiv(b, 4096), 3125);
            if (pr < 32'h8000_0000)
                pr = (pr << 1) / dv;
            else
                pr = (pr / dv) * 32'd2;
            e = pr / 32'd8;
            a = tdiv(wmul(p9, s32_t'((e * e) / 32'd8192)), 4096);
            b = tdiv(wmul(s32_t'(pr / 32'd4), p8), 8192);
            p_out = s32_t'(pr) + tdiv(a + b + p7, 16);
            fault = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t:%s", $realtime, msg);
    endtask

    // Register write over the configuration channel; caller drops valid afterwards
    task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TEMP_COEFFS: k_temp       = val[47:0];
            REG_PRESS_A:     k_press_a    = val;
            REG_PRESS_B:     k_press_b    = val;
            REG_PRESS_NINE:  k_press_nine = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_coeffs(input logic [47:0] tc, input logic [63:0] pa,
                               input logic [63:0] pb, input logic [15:0] p9);
        write_reg(REG_TEMP_COEFFS, {16'd0, tc});
        write_reg(REG_PRESS_A, pa);
        write_reg(REG_PRESS_B, pb);
        write_reg(REG_PRESS_NINE, {48'd0, p9});
        cfg_valid <= 1'b0;
    endtask

    // One request; optional idle burst before it
    task automatic send_pair(input logic [19:0] raw_t, input logic [19:0] raw_p,
                             input bit idle_en);
        logic [23:0] t;
        logic [31:0] p;
        logic        f;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_p, raw_t};
        do @(posedge clk); while (!s_tready);
        compensate(raw_t, raw_p, t, p, f);
        sb.note_request(t, p, f);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Raw values biased toward realistic sensor range with random extremes
    function automatic logic [19:0] pick_raw();
        case ($urandom_range(0, 5))
            0: return 20'd0;
            1: return 20'hFFFFF;
            2: return 20'($urandom);
            default: return 20'($urandom_range(300000, 700000));
        endcase
    endfunction

    // Output side: result checks, random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            string msg;
            msg = sb.check_result(m_tdata);
            if (msg != "")
                report_mismatch(msg);
        end
        if (long_hold_go && !long_hold_done)
        begin
            rx_hold        <= 300;
            m_tready       <= 1'b0;
            long_hold_done <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end
        else if (rx_idle_en && m_tready && $urandom_range(0, 9) == 0)
        begin
            rx_hold  <= $urandom_range(1, 16);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [63:0] r0, r1;
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        k_temp = '0;
        k_press_a = '0;
        k_press_b = '0;
        k_press_nine = '0;
        rx_idle_en = 0;
        long_hold_go = 0;
        mismatches = 0;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset coefficients: p1 is zero so every pressure faults
        send_pair(20'd0, 20'd0, 0);
        send_pair(20'hFFFFF, 20'hFFFFF, 0);
        drain();

        // Typical calibration set
        load_coeffs({16'hFE0C, 16'h6A1C, 16'd27504},
                    {16'h0B27, 16'hEFCD, 16'hD653, 16'd36477},
                    {16'hE9DC, 16'h000F, 16'hFFF9, 16'h008C}, 16'd6000);
        send_pair(20'd519888, 20'd415148, 0);
        send_pair(20'd0, 20'd0, 0);
        send_pair(20'hFFFFF, 20'hFFFFF, 0);
        send_pair(20'hFFFFF, 20'd0, 0);
        send_pair(20'd0, 20'hFFFFF, 0);
        send_pair(20'hAAAAA, 20'h55555, 0);
        send_pair(20'h55555, 20'hAAAAA, 0);
        drain();

        // Extreme coefficients: temperature saturation and wrap
        load_coeffs({16'h7FFF, 16'h7FFF, 16'hFFFF}, {4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
        send_pair(20'hFFFFF, 20'hFFFFF, 0);
        send_pair(20'd0, 20'd0, 0);
        send_pair(20'h12345, 20'h6789A, 0);
        drain();
        load_coeffs({16'h8000, 16'h8000, 16'd0}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
        send_pair(20'hFFFFF, 20'hFFFFF, 0);
        send_pair(20'd0, 20'd0, 0);
        drain();
        // Unknown index is ignored
        write_reg(8'd200, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_valid <= 1'b0;

        // Random phases: the typical calibration set first, then random coefficient sets
        for (int ph = 0; ph < 6; ph++)
        begin
            r0 = {$urandom, $urandom};
            r1 = {$urandom, $urandom};
            if (ph == 0)
                load_coeffs({16'hFE0C, 16'h6A1C, 16'd27504},
                            {16'h0B27, 16'hEFCD, 16'hD653, 16'd36477},
                            {16'hE9DC, 16'h000F, 16'hFFF9, 16'h008C}, 16'd6000);
            else
                load_coeffs({$urandom, 16'($urandom)}, r0, r1, 16'($urandom));
            rx_idle_en = (ph < 5);
            if (ph == 1)
                long_hold_go = 1'b1;
            for (int i = 0; i < 315; i++)
                send_pair(pick_raw(), pick_raw(), ph < 5);
            drain();
        end

        if (mismatches == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* baro_temp_press_compensate.f */
src/btpc_pkg.sv
src/baro_temp_press_compensate.sv
tb/sv/tb_top.sv
